>>> rtl/hpd_pkg.sv
`timescale 1ns / 1ps
package hpd_pkg;

  localparam int MaxCodeBits     = 30;
  localparam int BufferLimitBits = 56;
  localparam int BufW            = 64;
  localparam int CntW            = 7;
  localparam int NumSyms         = 257;

  typedef enum logic [1:0] {
    KIND_SYMBOL  = 2'd0,
    KIND_PAD_OK  = 2'd1,
    KIND_PAD_BAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  // Datapath commands from the controller
  typedef struct packed {
    logic load;      // append the accepted byte
    logic consume;   // strip the decoded head code
    logic clear;     // empty the buffer
  } hpd_cmd_t;

  // Datapath status for the controller
  typedef struct packed {
    logic       over_limit;
    logic       hit;
    logic       is_eos;
    logic [7:0] sym;
    logic       pad_ok;
  } hpd_sts_t;

  function automatic logic [4:0] len_count(input logic [4:0] l);
    case (l)
      5'd5:  len_count = 5'd10;
      5'd6:  len_count = 5'd26;
      5'd7:  len_count = 5'd0;   // 32 handled by width below
      5'd8:  len_count = 5'd6;
      5'd10: len_count = 5'd5;
      5'd11: len_count = 5'd3;
      5'd12: len_count = 5'd2;
      5'd13: len_count = 5'd6;
      5'd14: len_count = 5'd2;
      5'd15: len_count = 5'd3;
      5'd19: len_count = 5'd3;
      5'd20: len_count = 5'd8;
      5'd21: len_count = 5'd13;
      5'd22: len_count = 5'd26;
      5'd23: len_count = 5'd29;
      5'd24: len_count = 5'd12;
      5'd25: len_count = 5'd4;
      5'd26: len_count = 5'd15;
      5'd27: len_count = 5'd19;
      5'd28: len_count = 5'd29;
      5'd30: len_count = 5'd4;
      default: len_count = 5'd0;
    endcase
  endfunction

  // Count of codes of a length, widened so 32 fits
  function automatic logic [5:0] lcount(input logic [4:0] l);
    if (l == 5'd7) lcount = 6'd32;
    else lcount = {1'b0, len_count(l)};
  endfunction

  function automatic logic [8:0] canon_sym(input logic [8:0] i);
    logic [8:0] t [NumSyms];
    t = '{
      48, 49, 50, 97, 99, 101, 105, 111, 115, 116,
      32, 37, 45, 46, 47, 51, 52, 53, 54, 55, 56, 57, 61, 65, 95, 98, 100, 102,
      103, 104, 108, 109, 110, 112, 114, 117,
      58, 66, 67, 68, 69, 70, 71, 72, 73, 74, 75, 76, 77, 78, 79, 80, 81, 82,
      83, 84, 85, 86, 87, 89, 106, 107, 113, 118, 119, 120, 121, 122,
      38, 42, 44, 59, 88, 90,
      33, 34, 40, 41, 63,
      39, 43, 124,
      35, 62,
      0, 36, 64, 91, 93, 126,
      94, 125,
      60, 96, 123,
      92, 195, 208,
      128, 130, 131, 162, 184, 194, 224, 226,
      153, 161, 167, 172, 176, 177, 179, 209, 216, 217, 227, 229, 230,
      129, 132, 133, 134, 136, 146, 154, 156, 160, 163, 164, 169, 170, 173,
      178, 181, 185, 186, 187, 189, 190, 196, 198, 228, 232, 233,
      1, 135, 137, 138, 139, 140, 141, 143, 147, 149, 150, 151, 152, 155, 157,
      158, 165, 166, 168, 174, 175, 180, 182, 183, 188, 191, 197, 231, 239,
      9, 142, 144, 145, 148, 159, 171, 206, 215, 225, 236, 237,
      199, 207, 234, 235,
      192, 193, 200, 201, 202, 205, 210, 213, 218, 219, 238, 240, 242, 243, 255,
      203, 204, 211, 212, 214, 221, 222, 223, 241, 244, 245, 246, 247, 248, 250,
      251, 252, 253, 254,
      2, 3, 4, 5, 6, 7, 8, 11, 12, 14, 15, 16, 17, 18, 19, 20, 21, 23, 24, 25,
      26, 27, 28, 29, 30, 31, 127, 220, 249,
      10, 13, 22, 256
    };
    if (i < 9'(NumSyms)) canon_sym = t[i];
    else canon_sym = 9'd0;
  endfunction

endpackage

>>> rtl/hpd_if.sv
`timescale 1ns / 1ps
interface hpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_string;
  modport source (output valid, code_byte, end_of_string, input ready);
  modport sink (input valid, code_byte, end_of_string, output ready);
endinterface

interface hpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [1:0] kind;
  logic       last;
  modport source (output valid, symbol, kind, last, input ready);
  modport sink (input valid, symbol, kind, last, output ready);
endinterface

>>> rtl/hpack_huffman_stream_decoder.sv
`timescale 1ns / 1ps
// HPACK Huffman stream decoder (RFC 7541 code). One coded byte is taken per
// item; each decoded symbol, then an end-of-string padding verdict or an error,
// leaves as one result item, the final one of a byte flagged last. A byte is
// loaded in S_IDLE; each result then takes one decode step over the canonical
// length levels (S_DECODE) and one output state (S_EMIT). When the byte does
// not close with an end or error result, one more decode step finds no further
// code. A new byte is accepted only back in S_IDLE. A symbol is held back one
// stage until its last flag is known; output stalls hold the decoder in S_EMIT.
module hpack_huffman_stream_decoder #(
  parameter int BUFFER_LIMIT_BITS = hpd_pkg::BufferLimitBits
) (
  input  logic      clk,
  input  logic      rst_n,
  hpd_in_if.sink    in_ch,
  hpd_out_if.source out_ch
);
  import hpd_pkg::*;

  hpd_cmd_t  cmd;
  hpd_sts_t  sts;
  logic      step_end;
  hpd_out_if raw ();

  hpd_datapath #(.BUFFER_LIMIT_BITS(BUFFER_LIMIT_BITS)) u_dp (
    .clk, .rst_n, .byte_in(in_ch.code_byte), .cmd, .sts
  );

  hpd_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch(raw), .sts, .cmd, .step_end
  );

  hpd_lookahead u_la (
    .clk, .rst_n, .raw, .step_end, .out_ch
  );
endmodule

>>> rtl/hpd_datapath.sv
`timescale 1ns / 1ps
module hpd_datapath #(
  parameter int BUFFER_LIMIT_BITS = hpd_pkg::BufferLimitBits
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       byte_in,
  input  hpd_pkg::hpd_cmd_t cmd,
  output hpd_pkg::hpd_sts_t sts
);
  import hpd_pkg::*;

  logic [BufW-1:0] buf_r, buf_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // Canonical decode of the head code: one level per code length
  logic [4:0]  hit_len;
  logic [8:0]  hit_idx;
  logic        found;

  always_comb begin
    logic [29:0] code, first;
    logic [8:0]  base;
    logic [29:0] off;
    logic [6:0]  pos;
    code = '0; first = '0; base = '0;
    found = 1'b0; hit_len = '0; hit_idx = '0;
    for (int l = 1; l <= MaxCodeBits; l++) begin
      pos = cnt_r - 7'(l);
      code = {code[28:0], buf_r[pos[5:0]]};
      off = code - first;
      if (!found && (7'(l) <= cnt_r) && (off < 30'(lcount(5'(l))))) begin
        found = 1'b1;
        hit_len = 5'(l);
        hit_idx = base + off[8:0];
      end
      base = base + 9'(lcount(5'(l)));
      first = (first + 30'(lcount(5'(l)))) << 1;
    end
  end

  logic [8:0] sym9;
  assign sym9 = canon_sym(hit_idx);

  logic [BufW-1:0] mask_cnt;
  assign mask_cnt = (cnt_r >= 7'd64) ? '1 : ((64'd1 << cnt_r) - 64'd1);

  assign sts.over_limit = cnt_r > CntW'(BUFFER_LIMIT_BITS);
  assign sts.hit        = found;
  assign sts.is_eos     = sym9 == 9'd256;
  assign sts.sym        = sym9[7:0];
  assign sts.pad_ok     = (cnt_r <= 7'd7) && ((buf_r & mask_cnt) == mask_cnt);

  always_comb begin
    logic [CntW-1:0] rem;
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    rem = cnt_r - 7'(hit_len);
    if (cmd.clear) begin
      buf_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.load) begin
      buf_nxt = {buf_r[BufW-9:0], byte_in};
      cnt_nxt = cnt_r + 7'd8;
    end else if (cmd.consume) begin
      buf_nxt = buf_r & ((64'd1 << rem) - 64'd1);
      cnt_nxt = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= '0;
    end else begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

>>> rtl/hpd_ctrl.sv
`timescale 1ns / 1ps
module hpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  hpd_in_if.sink            in_ch,
  hpd_out_if.source         out_ch,
  input  hpd_pkg::hpd_sts_t sts,
  output hpd_pkg::hpd_cmd_t cmd,
  output logic              step_end
);
  import hpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECODE = 3'b010,
    S_EMIT   = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic        eos_r, eos_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  sym_r, sym_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        last_r, last_nxt;
  logic        done_r, done_nxt;   // item finished after this result

  assign in_ch.ready   = state_r == S_IDLE;
  assign out_ch.valid  = state_r == S_EMIT;
  assign out_ch.symbol = sym_r;
  assign out_ch.kind   = kind_r;
  assign out_ch.last   = last_r;

  // Byte finished without a closing result: the held symbol becomes the last
  assign step_end = (state_r == S_DECODE) && !ov_r && !sts.hit && !eos_r;

  always_comb begin
    state_nxt = state_r;
    eos_nxt = eos_r; ov_nxt = ov_r;
    sym_nxt = sym_r; kind_nxt = kind_r; last_nxt = last_r; done_nxt = done_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          eos_nxt = in_ch.end_of_string;
          ov_nxt  = sts.over_limit;
          if (sts.over_limit) cmd.clear = 1'b1;
          else cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        sym_nxt = 8'd0;
        last_nxt = 1'b0;
        done_nxt = 1'b0;
        state_nxt = S_EMIT;
        if (ov_r) begin
          kind_nxt = KIND_ERROR; last_nxt = 1'b1; done_nxt = 1'b1;
        end else if (sts.hit && sts.is_eos) begin
          cmd.clear = 1'b1;
          kind_nxt = KIND_ERROR; last_nxt = 1'b1; done_nxt = 1'b1;
        end else if (sts.hit) begin
          cmd.consume = 1'b1;
          kind_nxt = KIND_SYMBOL; sym_nxt = sts.sym;
        end else if (eos_r) begin
          cmd.clear = 1'b1;
          kind_nxt = sts.pad_ok ? KIND_PAD_OK : KIND_PAD_BAD;
          last_nxt = 1'b1; done_nxt = 1'b1;
        end else begin
          // no further code: step_end marks the held symbol as the last of this byte
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ch.ready) state_nxt = done_r ? S_IDLE : S_DECODE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Last flag for a trailing symbol: peek is not possible, so a symbol
  // result is held until the next decode step shows what follows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    eos_r <= eos_nxt; ov_r <= ov_nxt;
    sym_r <= sym_nxt; kind_r <= kind_nxt; last_r <= last_nxt;
  end
endmodule

>>> rtl/hpd_lookahead.sv
`timescale 1ns / 1ps
// Holds one result back so the last flag can be set once the next step is known.
module hpd_lookahead (
  input  logic      clk,
  input  logic      rst_n,
  hpd_out_if.sink   raw,
  input  logic      step_end,   // decoder returned to idle with no result
  hpd_out_if.source out_ch
);
  logic       hold_r;
  logic [7:0] sym_r;
  logic [1:0] kind_r;
  logic       last_r;

  // A raw result is taken when the hold is empty or is being flushed by it
  assign raw.ready = !hold_r || out_ch.ready;
  assign out_ch.valid  = hold_r && (raw.valid || step_end || last_r);
  assign out_ch.symbol = sym_r;
  assign out_ch.kind   = kind_r;
  assign out_ch.last   = last_r || (step_end && !raw.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (raw.valid && raw.ready) begin
      hold_r <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      hold_r <= 1'b0;
    end
    if (raw.valid && raw.ready) begin
      sym_r  <= raw.symbol;
      kind_r <= raw.kind;
      last_r <= raw.last;
    end else if (step_end && hold_r) begin
      last_r <= 1'b1;
    end
  end
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import hpd_pkg::*;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_string;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    kind_t      kind;
    logic       last;
  } decode_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  hpd_in_if  in_ch ();
  hpd_out_if out_ch ();

  hpack_huffman_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Canonical code tables, rebuilt locally
  int unsigned code_len [257];
  int unsigned code_val [257];
  int unsigned sym_order [257];
  int unsigned len_tally [31];

  logic [63:0] pend_bits;
  int unsigned pend_cnt;

  byte_item_t  byte_q [$];
  decode_res_t expect_q [$];

  int errors;
  int n_results;
  int n_errs;
  int n_pad_bad;
  int n_bytes;
  longint cycles;
  bit hold_rx;
  bit quiet;
  bit in_acc;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void init_tables();
    int unsigned c;
    int unsigned k;
    len_tally = '{0, 0, 0, 0, 0, 10, 26, 32, 6, 0, 5, 3, 2, 6, 2, 3,
                  0, 0, 0, 3, 8, 13, 26, 29, 12, 4, 15, 19, 29, 0, 4};
    sym_order = '{
      48, 49, 50, 97, 99, 101, 105, 111, 115, 116,
      32, 37, 45, 46, 47, 51, 52, 53, 54, 55, 56, 57, 61, 65, 95, 98, 100, 102,
      103, 104, 108, 109, 110, 112, 114, 117,
      58, 66, 67, 68, 69, 70, 71, 72, 73, 74, 75, 76, 77, 78, 79, 80, 81, 82,
      83, 84, 85, 86, 87, 89, 106, 107, 113, 118, 119, 120, 121, 122,
      38, 42, 44, 59, 88, 90, 33, 34, 40, 41, 63, 39, 43, 124, 35, 62,
      0, 36, 64, 91, 93, 126, 94, 125, 60, 96, 123, 92, 195, 208,
      128, 130, 131, 162, 184, 194, 224, 226,
      153, 161, 167, 172, 176, 177, 179, 209, 216, 217, 227, 229, 230,
      129, 132, 133, 134, 136, 146, 154, 156, 160, 163, 164, 169, 170, 173,
      178, 181, 185, 186, 187, 189, 190, 196, 198, 228, 232, 233,
      1, 135, 137, 138, 139, 140, 141, 143, 147, 149, 150, 151, 152, 155, 157,
      158, 165, 166, 168, 174, 175, 180, 182, 183, 188, 191, 197, 231, 239,
      9, 142, 144, 145, 148, 159, 171, 206, 215, 225, 236, 237,
      199, 207, 234, 235,
      192, 193, 200, 201, 202, 205, 210, 213, 218, 219, 238, 240, 242, 243, 255,
      203, 204, 211, 212, 214, 221, 222, 223, 241, 244, 245, 246, 247, 248, 250,
      251, 252, 253, 254,
      2, 3, 4, 5, 6, 7, 8, 11, 12, 14, 15, 16, 17, 18, 19, 20, 21, 23, 24, 25,
      26, 27, 28, 29, 30, 31, 127, 220, 249,
      10, 13, 22, 256};
    c = 0;
    k = 0;
    for (int l = 1; l <= 30; l++) begin
      for (int j = 0; j < len_tally[l]; j++) begin
        code_len[sym_order[k]] = l;
        code_val[sym_order[k]] = c;
        c++;
        k++;
      end
      c = c << 1;
    end
  endfunction

  function automatic void clear_buffer();
    pend_bits = '0;
    pend_cnt = 0;
  endfunction

  // Length of the code at the head of the buffer, 0 if incomplete
  function automatic int unsigned head_match(output int unsigned sym);
    int unsigned c;
    int unsigned first;
    int unsigned base;
    int unsigned lim;
    c = 0;
    first = 0;
    base = 0;
    sym = 0;
    lim = (pend_cnt > MaxCodeBits) ? MaxCodeBits : pend_cnt;
    for (int unsigned l = 1; l <= lim; l++) begin
      c = (c << 1) | 32'(pend_bits[pend_cnt - l]);
      if (c - first < len_tally[l]) begin
        sym = sym_order[base + c - first];
        return l;
      end
      base += len_tally[l];
      first = (first + len_tally[l]) << 1;
    end
    return 0;
  endfunction

  function automatic void push_result(input logic [7:0] s, input kind_t k);
    decode_res_t r;
    r.symbol = s;
    r.kind = k;
    r.last = 1'b0;
    expect_q.push_back(r);
  endfunction

  function automatic void predict_byte(input byte_item_t it);
    int unsigned len;
    int unsigned sym;
    int start;
    bit failed;
    logic [63:0] ones;
    start = expect_q.size();
    failed = 0;
    if (pend_cnt > BufferLimitBits) begin
      push_result(8'd0, KIND_ERROR);
      clear_buffer();
      failed = 1;
    end else begin
      pend_bits = (pend_bits << 8) | 64'(it.code_byte);
      pend_cnt += 8;
      forever begin
        len = head_match(sym);
        if (len == 0) break;
        pend_cnt -= len;
        pend_bits &= (64'd1 << pend_cnt) - 64'd1;
        if (sym == 256) begin
          push_result(8'd0, KIND_ERROR);
          clear_buffer();
          failed = 1;
          break;
        end
        push_result(sym[7:0], KIND_SYMBOL);
      end
    end
    if (!failed && it.end_of_string) begin
      ones = (64'd1 << pend_cnt) - 64'd1;
      push_result(8'd0, (pend_cnt <= 7 && pend_bits == ones) ? KIND_PAD_OK : KIND_PAD_BAD);
      clear_buffer();
    end
    if (expect_q.size() > start) expect_q[$].last = 1'b1;
  endfunction

  // Encode a string of symbols into bytes, optionally with bad padding
  task automatic queue_string(input int unsigned syms [$], input int pad_mode);
    logic [63:0] acc;
    int unsigned nb;
    byte_item_t it;
    acc = '0;
    nb = 0;
    foreach (syms[i]) begin
      acc = (acc << code_len[syms[i]]) | 64'(code_val[syms[i]]);
      nb += code_len[syms[i]];
      while (nb >= 8) begin
        it.code_byte = 8'(acc >> (nb - 8));
        it.end_of_string = 1'b0;
        byte_q.push_back(it);
        nb -= 8;
      end
    end
    if (nb > 0 || pad_mode != 0) begin
      if (nb == 0) begin
        it.code_byte = 8'hff;
      end else begin
        it.code_byte = 8'((acc << (8 - nb)) | ((64'd1 << (8 - nb)) - 1));
        if (pad_mode != 0) it.code_byte[0] = 1'b0;
      end
      it.end_of_string = 1'b1;
      byte_q.push_back(it);
    end else if (byte_q.size() > 0) begin
      byte_q[$].end_of_string = 1'b1;
    end
  endtask

  task automatic queue_raw(input logic [7:0] b, input logic e);
    byte_item_t it;
    it.code_byte = b;
    it.end_of_string = e;
    byte_q.push_back(it);
  endtask

  // Input acceptance, seen at the rising edge
  always @(posedge clk) begin
    in_acc <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_acc) begin
      // hold
    end else begin
      if (in_acc) begin
        predict_byte('{in_ch.code_byte, in_ch.end_of_string});
        n_bytes++;
        void'(byte_q.pop_front());
      end
      if (byte_q.size() > 0 && (quiet || $urandom_range(99) >= 22)) begin
        in_ch.valid <= 1'b1;
        in_ch.code_byte <= byte_q[0].code_byte;
        in_ch.end_of_string <= byte_q[0].end_of_string;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, held low through the hold-off stretch
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= !hold_rx && (quiet || $urandom_range(99) >= 22);
    else out_ch.ready <= 1'b0;
  end

  // Monitor
  always @(posedge clk) begin
    decode_res_t got;
    decode_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.symbol = out_ch.symbol;
      got.kind = kind_t'(out_ch.kind);
      got.last = out_ch.last;
      n_results++;
      if (got.kind == KIND_ERROR) n_errs++;
      if (got.kind == KIND_PAD_BAD) n_pad_bad++;
      if (expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result sym=%0d kind=%0d last=%0b",
                                  got.symbol, got.kind, got.last));
      end else begin
        want = expect_q.pop_front();
        if (got.symbol !== want.symbol)
          report_mismatch($sformatf("symbol %0d, want %0d", got.symbol, want.symbol));
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    hold_rx = 1'b0;
    wait (n_bytes >= 60);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    int unsigned syms [$];
    int unsigned n;
    int pick;
    in_ch.valid = 1'b0;
    in_ch.code_byte = '0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready = 1'b0;
    errors = 0;
    n_results = 0;
    n_errs = 0;
    n_pad_bad = 0;
    n_bytes = 0;
    cycles = 0;
    quiet = 1'b0;
    init_tables();
    clear_buffer();

    // Directed: short and long codes, padding cases, EOS
    queue_string('{48, 49}, 0);               // 5-bit codes
    queue_string('{10, 13, 22}, 0);           // longest codes
    queue_string('{97}, 1);                   // zero in padding
    queue_raw(8'hff, 1'b1);                   // eight bits of padding
    queue_raw(8'h00, 1'b1);                   // all zero byte
    queue_raw(8'hff, 1'b0);                   // EOS across four bytes
    queue_raw(8'hff, 1'b0);
    queue_raw(8'hff, 1'b0);
    queue_raw(8'hff, 1'b1);
    // Long runs of ones broken by a single zero
    for (int i = 0; i < 3; i++) queue_raw(8'hff, 1'b0);
    queue_raw(8'hfe, 1'b0);
    for (int i = 0; i < 4; i++) queue_raw(8'hff, 1'b0);
    queue_raw(8'h7f, 1'b1);
    queue_string('{0, 255, 127}, 0);

    while (byte_q.size() + n_bytes < 280) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        syms.delete();
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          syms.push_back($urandom_range(3) == 0 ? $urandom_range(255)
                                                : sym_order[$urandom_range(35)]);
        queue_string(syms, $urandom_range(9) == 0);
      end else if (pick < 90) begin
        queue_raw(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        for (int i = 0; i < 4; i++) queue_raw(8'hff, 1'b0);
        queue_raw(8'($urandom_range(255)), 1'b1);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Idle-free stretch in the middle
    wait (n_bytes >= 150);
    quiet = 1'b1;
    wait (n_bytes >= 200);
    quiet = 1'b0;
    wait (byte_q.size() == 0 && !in_ch.valid);
    wait (expect_q.size() == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d bytes, %0d results (%0d errors, %0d bad padding)",
             n_bytes, n_results, n_errs, n_pad_bad);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
